FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; they are empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/hlsrgb_pkg.sv
// Types, constants and helper functions of the HLS to RGB converter.
`default_nettype none
package hlsrgb_pkg;

  typedef logic [7:0]  level_t;   // 8-bit code or output level
  typedef logic [8:0]  hue_t;     // hue in half-codes, 0..510
  typedef logic [15:0] m_t;       // m1/m2 in units of 1/65025
  typedef logic [6:0]  ramp_t;    // ramp weight, 0..85
  typedef logic [22:0] n_t;       // channel value in units of 1/21675 step
  typedef logic [23:0] num_t;     // rounded numerator
  typedef logic [40:0] prod_t;    // numerator times reciprocal
  typedef logic [8:0]  quot_t;    // quotient before clamp

  localparam int unsigned CHANNELS = 3;
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  // Hue segment bounds in half-codes (60, 180, 240, 360 degrees)
  localparam hue_t       RAMP_END   = 9'd85;
  localparam hue_t       FLAT_END   = 9'd255;
  localparam hue_t       FALL_END   = 9'd340;
  localparam logic [9:0] HALF_TURN  = 10'd510;
  localparam logic [9:0] HUE_OFFSET = 10'd170;   // 120 degrees
  localparam logic [9:0] BLUE_WRAP  = 10'd340;   // 510 - 170
  localparam ramp_t      RAMP_LEN   = 7'd85;

  // Rounding: q = floor((2N + 21675) / 43350)
  localparam logic [14:0] ROUND_BIAS  = 15'd21675;
  localparam logic [15:0] DIVISOR     = 16'd43350;
  localparam logic [16:0] RECIP       = 17'd99076;   // floor(2^32 / 43350)
  localparam int unsigned RECIP_SHIFT = 32;
  localparam m_t          M_MAX       = 16'd65025;
  localparam level_t      LEVEL_MAX   = 8'd255;

  // Word from the front stages: m1, m2 - m1 and one ramp weight per channel
  typedef struct packed {
    m_t                   m1;
    m_t                   d;
    ramp_t [CHANNELS-1:0] t;
    logic                 row_end;
  } front_t;

  // Word from the ramp stage: unrounded channel values
  typedef struct packed {
    n_t [CHANNELS-1:0] n;
    logic              row_end;
  } ramp_word_t;

  // Ramp weight for a hue position: N = 85*m1 + (m2 - m1)*weight
  function automatic ramp_t ramp_weight(input hue_t x);
    hue_t fall;
    fall = FALL_END - x;
    if (x < RAMP_END) begin
      return x[6:0];
    end else if (x < FLAT_END) begin
      return RAMP_LEN;
    end else if (x < FALL_END) begin
      return fall[6:0];
    end else begin
      return 7'd0;
    end
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/hlsrgb_front.sv
// Front stages: m1/m2 from intensity and saturation, hue offsets and ramp weights.
`default_nettype none
module hlsrgb_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hlsrgb_pkg::level_t  hue_code,
  input  wire hlsrgb_pkg::level_t  intensity_code,
  input  wire hlsrgb_pkg::level_t  saturation_code,
  input  wire logic                row_end,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hlsrgb_pkg::front_t       out_word
);

  // stage 1 registers
  logic                                          v1;
  hlsrgb_pkg::m_t                                m2;
  hlsrgb_pkg::level_t                            inten;
  hlsrgb_pkg::ramp_t [hlsrgb_pkg::CHANNELS-1:0]  t1;
  logic                                          row_end1;
  // stage 2 registers
  logic                                          v2;
  hlsrgb_pkg::front_t                            word2;

  logic                                          en1;
  logic                                          en2;
  logic [15:0]                                   prod_is;
  logic [16:0]                                   i255;
  logic [16:0]                                   s255;
  logic [16:0]                                   m2_next;
  hlsrgb_pkg::hue_t                              hx;
  logic [9:0]                                    red_pos;
  logic [9:0]                                    blue_pos;
  logic [16:0]                                   i510;
  logic [16:0]                                   m1_wide;
  hlsrgb_pkg::m_t                                m1_next;

  // stall chain
  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // m2 from intensity and saturation
  always_comb begin
    prod_is = 16'(intensity_code) * 16'(saturation_code);
    i255    = {1'b0, intensity_code, 8'd0} - 17'(intensity_code);
    s255    = {1'b0, saturation_code, 8'd0} - 17'(saturation_code);
    if (!intensity_code[7]) begin
      m2_next = i255 + 17'(prod_is);
    end else begin
      m2_next = i255 + s255 - 17'(prod_is);
    end
  end

  // hue positions for red (+120 deg) and blue (-120 deg), wrapped to one turn
  always_comb begin
    hx      = {hue_code, 1'b0};
    red_pos = 10'(hx) + hlsrgb_pkg::HUE_OFFSET;
    if (red_pos > hlsrgb_pkg::HALF_TURN) begin
      red_pos = red_pos - hlsrgb_pkg::HALF_TURN;
    end
    if (10'(hx) < hlsrgb_pkg::HUE_OFFSET) begin
      blue_pos = 10'(hx) + hlsrgb_pkg::BLUE_WRAP;
    end else begin
      blue_pos = 10'(hx) - hlsrgb_pkg::HUE_OFFSET;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1 && in_valid) begin
      m2                            <= m2_next[15:0];
      inten                         <= intensity_code;
      t1[hlsrgb_pkg::CH_RED]        <= hlsrgb_pkg::ramp_weight(red_pos[8:0]);
      t1[hlsrgb_pkg::CH_GREEN]      <= hlsrgb_pkg::ramp_weight(hx);
      t1[hlsrgb_pkg::CH_BLUE]       <= hlsrgb_pkg::ramp_weight(blue_pos[8:0]);
      row_end1                      <= row_end;
    end
  end

  // m1 = 2*l - m2
  always_comb begin
    i510    = {inten, 9'd0} - {8'd0, inten, 1'b0};
    m1_wide = i510 - 17'(m2);
    m1_next = m1_wide[15:0];
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2 && v1) begin
      word2.m1      <= m1_next;
      word2.d       <= m2 - m1_next;
      word2.t       <= t1;
      word2.row_end <= row_end1;
    end
  end

  assign out_valid = v2;
  assign out_word  = word2;

endmodule
`default_nettype wire

FILE: hw/rtl/hlsrgb_ramp.sv
// Ramp stage: unrounded channel values N = 85*m1 + (m2 - m1)*weight.
`default_nettype none
module hlsrgb_ramp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hlsrgb_pkg::front_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hlsrgb_pkg::ramp_word_t   out_word
);

  logic                   v;
  hlsrgb_pkg::ramp_word_t word;
  logic                   en;
  hlsrgb_pkg::n_t         base;
  hlsrgb_pkg::ramp_word_t word_next;

  assign en       = !v || out_ready;
  assign in_ready = en;

  // one multiplier per channel, common 85*m1 term
  always_comb begin
    base = hlsrgb_pkg::n_t'(in_word.m1) * hlsrgb_pkg::n_t'(hlsrgb_pkg::RAMP_LEN);
    for (int c = 0; c < hlsrgb_pkg::CHANNELS; c++) begin
      word_next.n[c] = base + hlsrgb_pkg::n_t'(in_word.d) * hlsrgb_pkg::n_t'(in_word.t[c]);
    end
    word_next.row_end = in_word.row_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
    if (en && in_valid) begin
      word <= word_next;
    end
  end

  assign out_valid = v;
  assign out_word  = word;

endmodule
`default_nettype wire

FILE: hw/rtl/hlsrgb_round.sv
// Rounding stages: divide by 43350 through a reciprocal, correct, clamp, output register.
`default_nettype none
module hlsrgb_round (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire hlsrgb_pkg::ramp_word_t in_word,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output hlsrgb_pkg::level_t          red_level,
  output hlsrgb_pkg::level_t          green_level,
  output hlsrgb_pkg::level_t          blue_level,
  output logic                        row_end_out
);

  localparam int unsigned QHI = hlsrgb_pkg::RECIP_SHIFT + $bits(hlsrgb_pkg::quot_t) - 1;

  // stage A: numerator and quotient estimate
  logic                                          va;
  hlsrgb_pkg::num_t  [hlsrgb_pkg::CHANNELS-1:0]  num_a;
  hlsrgb_pkg::quot_t [hlsrgb_pkg::CHANNELS-1:0]  qest_a;
  logic                                          row_end_a;
  // stage B: estimate times divisor
  logic                                          vb;
  hlsrgb_pkg::num_t  [hlsrgb_pkg::CHANNELS-1:0]  num_b;
  hlsrgb_pkg::quot_t [hlsrgb_pkg::CHANNELS-1:0]  qest_b;
  hlsrgb_pkg::num_t  [hlsrgb_pkg::CHANNELS-1:0]  back_b;
  logic                                          row_end_b;
  // stage C: output word
  logic                                          vc;
  hlsrgb_pkg::level_t [hlsrgb_pkg::CHANNELS-1:0] level_c;
  logic                                          row_end_c;

  logic                                          ena;
  logic                                          enb;
  logic                                          enc;
  hlsrgb_pkg::num_t  [hlsrgb_pkg::CHANNELS-1:0]  num_next;
  hlsrgb_pkg::prod_t [hlsrgb_pkg::CHANNELS-1:0]  prod;
  hlsrgb_pkg::num_t  [hlsrgb_pkg::CHANNELS-1:0]  rem;
  hlsrgb_pkg::quot_t [hlsrgb_pkg::CHANNELS-1:0]  quot;
  hlsrgb_pkg::level_t [hlsrgb_pkg::CHANNELS-1:0] level_next;

  // stall chain
  assign enc      = !vc || out_ready;
  assign enb      = !vb || enc;
  assign ena      = !va || enb;
  assign in_ready = ena;

  // 2N + bias, times floor(2^32 / 43350); estimate is exact or one short
  always_comb begin
    for (int c = 0; c < hlsrgb_pkg::CHANNELS; c++) begin
      num_next[c] = {in_word.n[c], 1'b0} + hlsrgb_pkg::num_t'(hlsrgb_pkg::ROUND_BIAS);
      prod[c]     = hlsrgb_pkg::prod_t'(num_next[c]) * hlsrgb_pkg::prod_t'(hlsrgb_pkg::RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (ena) begin
      va <= in_valid;
    end
    if (ena && in_valid) begin
      for (int c = 0; c < hlsrgb_pkg::CHANNELS; c++) begin
        num_a[c]  <= num_next[c];
        qest_a[c] <= prod[c][QHI:hlsrgb_pkg::RECIP_SHIFT];
      end
      row_end_a <= in_word.row_end;
    end
  end

  // back-multiply the estimate
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (enb) begin
      vb <= va;
    end
    if (enb && va) begin
      for (int c = 0; c < hlsrgb_pkg::CHANNELS; c++) begin
        num_b[c]  <= num_a[c];
        qest_b[c] <= qest_a[c];
        back_b[c] <= hlsrgb_pkg::num_t'(qest_a[c]) * hlsrgb_pkg::num_t'(hlsrgb_pkg::DIVISOR);
      end
      row_end_b <= row_end_a;
    end
  end

  // remainder check, one-step correction and clamp
  always_comb begin
    for (int c = 0; c < hlsrgb_pkg::CHANNELS; c++) begin
      rem[c] = num_b[c] - back_b[c];
      if (rem[c] >= hlsrgb_pkg::num_t'(hlsrgb_pkg::DIVISOR)) begin
        quot[c] = qest_b[c] + 9'd1;
      end else begin
        quot[c] = qest_b[c];
      end
      if (quot[c] > hlsrgb_pkg::quot_t'(hlsrgb_pkg::LEVEL_MAX)) begin
        level_next[c] = hlsrgb_pkg::LEVEL_MAX;
      end else begin
        level_next[c] = quot[c][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (enc) begin
      vc <= vb;
    end
    if (enc && vb) begin
      level_c   <= level_next;
      row_end_c <= row_end_b;
    end
  end

  assign out_valid   = vc;
  assign red_level   = level_c[hlsrgb_pkg::CH_RED];
  assign green_level = level_c[hlsrgb_pkg::CH_GREEN];
  assign blue_level  = level_c[hlsrgb_pkg::CH_BLUE];
  assign row_end_out = row_end_c;

endmodule
`default_nettype wire

FILE: hw/rtl/hls_to_rgb_pixel_converter_top.sv
// Top level of the HLS to RGB pixel converter.
// Converts one pixel of 8-bit hue, intensity and saturation codes per clock into
// 8-bit red, green and blue levels (rounded half up, clamped to 255); zero
// saturation gives grey equal to intensity, and row_end is carried alongside.
// The pipeline has six register stages; throughput is one pixel per clock
// while the output is not stalled, set by the fully pipelined multipliers
// (one per channel in the ramp stage, two per channel in the rounding
// stages). Every stage has its own valid bit and a stage takes a
// new word whenever it is empty or its word moves on, so back-pressure on the
// output fills bubbles first and drops nothing. No state is kept between pixels.
`default_nettype none
`include "assert_macros.svh"
module hls_to_rgb_pixel_converter_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hlsrgb_pkg::level_t  hue_code,
  input  wire hlsrgb_pkg::level_t  intensity_code,
  input  wire hlsrgb_pkg::level_t  saturation_code,
  input  wire logic                row_end,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hlsrgb_pkg::level_t       red_level,
  output hlsrgb_pkg::level_t       green_level,
  output hlsrgb_pkg::level_t       blue_level,
  output logic                     row_end_out
);

  logic                   front_valid;
  logic                   front_ready;
  hlsrgb_pkg::front_t     front_word;
  logic                   ramp_valid;
  logic                   ramp_ready;
  hlsrgb_pkg::ramp_word_t ramp_word;
  logic [16:0]            front_m2;
  logic                   front_weights_ok;
  logic [24:0]            out_bits;

  hlsrgb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .hue_code        (hue_code),
    .intensity_code  (intensity_code),
    .saturation_code (saturation_code),
    .row_end         (row_end),
    .out_valid       (front_valid),
    .out_ready       (front_ready),
    .out_word        (front_word)
  );

  hlsrgb_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_word   (front_word),
    .out_valid (ramp_valid),
    .out_ready (ramp_ready),
    .out_word  (ramp_word)
  );

  hlsrgb_round u_round (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (ramp_valid),
    .in_ready    (ramp_ready),
    .in_word     (ramp_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level),
    .row_end_out (row_end_out)
  );

  // checker views of the front word and the output word
  assign front_m2         = 17'(front_word.m1) + 17'(front_word.d);
  assign front_weights_ok = (front_word.t[hlsrgb_pkg::CH_RED]   <= hlsrgb_pkg::RAMP_LEN) &&
                            (front_word.t[hlsrgb_pkg::CH_GREEN] <= hlsrgb_pkg::RAMP_LEN) &&
                            (front_word.t[hlsrgb_pkg::CH_BLUE]  <= hlsrgb_pkg::RAMP_LEN);
  assign out_bits         = {red_level, green_level, blue_level, row_end_out};

  // input is refused only when every stage is full and the output is stalled
  `ASSERT_IMPLIES(a_stall_only_when_full, clk, rst, !in_ready, out_valid && !out_ready)
  // m2 = m1 + d never exceeds 65025
  `ASSERT_IMPLIES(a_m2_in_range, clk, rst, front_valid, front_m2 <= 17'(hlsrgb_pkg::M_MAX))
  // ramp weights never exceed 85
  `ASSERT_IMPLIES(a_weights_in_range, clk, rst, front_valid, front_weights_ok)
  // a stalled output word stays put until taken
  `ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ready, out_valid && $stable(out_bits))

endmodule
`default_nettype wire
